// ===== design/tga_pixel_stream_decoder_defines.svh =====
// assertion macros shared by the tga pixel stream decoder
`ifndef TGA_PIXEL_STREAM_DECODER_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_DEFINES_SVH

// same-cycle implication on i_clk, held off while i_rst_n is low
`define TPSD_CHECK(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpsd check failed");

// next-cycle implication on i_clk, held off while i_rst_n is low
`define TPSD_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpsd check failed");

`endif

// ===== design/tpsd_pkg.sv =====
// shared types and constants of the tga pixel stream decoder
package tpsd_pkg;

    localparam int CFG_DW      = 13;
    localparam int CFG_AW      = 3;
    localparam int CFG_DIM_MAX = 8191;

    localparam logic [CFG_AW-1:0] REG_WIDTH_PX     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HEIGHT_PX    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PIXEL_FORMAT = 3'd2;
    localparam logic [CFG_AW-1:0] REG_RLE          = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TOP_ORIGIN   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_RIGHT_ORIGIN = 3'd5;

    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;

    localparam logic [7:0] RUN_BIAS     = 8'd127;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;
    localparam logic [QUEUE_CW-1:0] QUEUE_COUNT_FULL = QUEUE_CW'(QUEUE_DEPTH);

    typedef struct packed {
        logic [CFG_DW-1:0] width_px;
        logic [CFG_DW-1:0] height_px;
        logic [1:0]        pixel_format;
        logic              run_length_packed;
        logic              top_origin;
        logic              right_origin;
    } t_cfg;

    typedef struct packed {
        logic       clr;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] rep;
    } t_pix;

endpackage

// ===== design/tpsd_front.sv =====
// byte front end: packet headers, pixel assembly and colour decode
module tpsd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpsd_pkg::t_cfg    i_cfg,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_image,
    output logic              o_push,
    output tpsd_pkg::t_pix    o_pix
);

    logic [1:0]  r_phase, n_phase;
    logic [23:0] r_bytes, n_bytes;
    logic [7:0]  r_left, n_left;
    logic        r_is_run, n_is_run;
    logic        r_await, n_await;
    logic        r_clr_pend, n_clr_pend;

    logic [1:0]  c_phase;
    logic [23:0] c_bytes;
    logic [7:0]  c_left;
    logic        c_is_run;
    logic        c_await;
    logic        c_clr;
    logic [2:0]  need;
    logic [31:0] word;
    logic [7:0]  left_dec;

    always_comb begin
        c_phase  = i_start_image ? 2'd0 : r_phase;
        c_bytes  = i_start_image ? 24'd0 : r_bytes;
        c_left   = i_start_image ? 8'd0 : r_left;
        c_is_run = i_start_image ? 1'b0 : r_is_run;
        c_await  = i_start_image ? 1'b1 : r_await;
        c_clr    = i_start_image | r_clr_pend;

        case (i_cfg.pixel_format)
            tpsd_pkg::FMT_16: need = 3'd2;
            tpsd_pkg::FMT_24: need = 3'd3;
            default:          need = 3'd4;
        endcase

        word     = {8'd0, c_bytes} | ({24'd0, i_data_byte} << {c_phase, 3'b000});
        left_dec = (c_left != 8'd0) ? (c_left - 8'd1) : c_left;

        n_phase    = r_phase;
        n_bytes    = r_bytes;
        n_left     = r_left;
        n_is_run   = r_is_run;
        n_await    = r_await;
        n_clr_pend = r_clr_pend;
        o_push     = 1'b0;

        o_pix.clr = c_clr;
        if (i_cfg.pixel_format == tpsd_pkg::FMT_16) begin
            o_pix.red   = {word[14:10], 3'b000};
            o_pix.green = {word[9:5], 3'b000};
            o_pix.blue  = {word[4:0], 3'b000};
            o_pix.alpha = tpsd_pkg::ALPHA_OPAQUE;
        end else begin
            o_pix.red   = word[23:16];
            o_pix.green = word[15:8];
            o_pix.blue  = word[7:0];
            o_pix.alpha = (i_cfg.pixel_format == tpsd_pkg::FMT_24) ?
                          tpsd_pkg::ALPHA_OPAQUE : word[31:24];
        end
        if (i_cfg.run_length_packed && c_is_run) begin
            o_pix.rep = c_left;
        end else begin
            o_pix.rep = 8'd1;
        end

        if (i_accept) begin
            n_phase    = c_phase;
            n_bytes    = c_bytes;
            n_left     = c_left;
            n_is_run   = c_is_run;
            n_await    = c_await;
            n_clr_pend = c_clr;
            if (i_cfg.run_length_packed && c_await) begin
                n_is_run = i_data_byte[7];
                n_left   = i_data_byte[7] ? (i_data_byte - tpsd_pkg::RUN_BIAS)
                                          : (i_data_byte + 8'd1);
                n_await  = 1'b0;
            end else if ({1'b0, c_phase} + 3'd1 < need) begin
                n_bytes = word[23:0];
                n_phase = c_phase + 2'd1;
            end else begin
                n_phase    = 2'd0;
                n_bytes    = 24'd0;
                n_clr_pend = 1'b0;
                o_push     = 1'b1;
                if (i_cfg.run_length_packed) begin
                    if (c_is_run) begin
                        n_left  = 8'd0;
                        n_await = 1'b1;
                    end else begin
                        n_left = left_dec;
                        if (left_dec == 8'd0) begin
                            n_await = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 2'd0;
            r_bytes    <= 24'd0;
            r_left     <= 8'd0;
            r_is_run   <= 1'b0;
            r_await    <= 1'b1;
            r_clr_pend <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_bytes    <= n_bytes;
            r_left     <= n_left;
            r_is_run   <= n_is_run;
            r_await    <= n_await;
            r_clr_pend <= n_clr_pend;
        end
    end

endmodule

// ===== design/tpsd_queue.sv =====
// short pixel queue between front end and back end
module tpsd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpsd_pkg::t_pix i_data,
    input  logic           i_pop,
    output tpsd_pkg::t_pix o_data,
    output logic           o_full,
    output logic           o_empty
);

    tpsd_pkg::t_pix r_mem [tpsd_pkg::QUEUE_DEPTH];
    logic [tpsd_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [tpsd_pkg::QUEUE_CW-1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == tpsd_pkg::QUEUE_COUNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/tpsd_back.sv =====
// back end: clipping, position and coordinate update, result register
module tpsd_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpsd_pkg::t_cfg i_cfg,
    input  tpsd_pkg::t_pix i_q_data,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic [7:0]     o_alpha,
    output logic [23:0]    o_file_index,
    output logic [7:0]     o_repeat_count,
    output logic [11:0]    o_dest_x,
    output logic [11:0]    o_dest_y,
    output logic           o_image_done,
    output logic           o_out_load
);

    localparam int CAP_W = (MAX_WIDTH < tpsd_pkg::CFG_DIM_MAX) ? MAX_WIDTH
                                                               : tpsd_pkg::CFG_DIM_MAX;
    localparam int CAP_H = (MAX_HEIGHT < tpsd_pkg::CFG_DIM_MAX) ? MAX_HEIGHT
                                                                : tpsd_pkg::CFG_DIM_MAX;
    localparam int XW  = $clog2(CAP_W + 1);
    localparam int YW  = $clog2(CAP_H + 1);
    localparam int PW  = XW + YW;
    localparam int RCW = (PW > 8) ? PW : 8;
    localparam int C2W = ((XW > 8) ? XW : 8) + 1;
    localparam int QW  = C2W;
    localparam int KW  = $clog2(QW);
    localparam int DW  = C2W + XW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;

    logic [XW-1:0]  r_ew, n_ew;
    logic [YW-1:0]  r_eh, n_eh;
    logic [PW-1:0]  r_total, n_total;

    logic [PW-1:0]  r_pos;
    logic [XW-1:0]  r_col;
    logic [YW-1:0]  r_row;

    logic [7:0]     r_red, r_green, r_blue, r_alpha, r_rep;
    logic [23:0]    r_res_index;
    logic [7:0]     r_res_rep;
    logic [11:0]    r_res_x, r_res_y;
    logic [C2W-1:0] r_div;
    logic [QW-1:0]  r_quo;
    logic [KW-1:0]  r_k;

    logic           r_out_valid;
    logic [7:0]     r_o_red, r_o_green, r_o_blue, r_o_alpha, r_o_rep;
    logic [23:0]    r_o_index;
    logic [11:0]    r_o_x, r_o_y;
    logic           r_o_done;

    logic [PW-1:0]  rem;
    logic [RCW-1:0] rem_x, rep_x;
    logic [7:0]     rep_c;
    logic [C2W-1:0] col2;
    logic [XW-1:0]  dx;
    logic [YW-1:0]  dy;
    logic [DW-1:0]  shifted;
    logic           div_ge;
    logic [C2W-1:0] n_div;
    logic [QW-1:0]  n_quo;

    always_comb begin
        n_ew = (32'(i_cfg.width_px) > 32'(MAX_WIDTH)) ? XW'(CAP_W)
                                                      : XW'(i_cfg.width_px);
        n_eh = (32'(i_cfg.height_px) > 32'(MAX_HEIGHT)) ? YW'(CAP_H)
                                                        : YW'(i_cfg.height_px);
        n_total = PW'(r_ew) * PW'(r_eh);

        rem   = r_total - r_pos;
        rem_x = RCW'(rem);
        rep_x = RCW'(r_rep);
        rep_c = (rep_x > rem_x) ? rem_x[7:0] : r_rep;
        col2  = C2W'(r_col) + C2W'(rep_c);
        dx    = i_cfg.right_origin ? (r_ew - XW'(1) - r_col) : r_col;
        dy    = i_cfg.top_origin ? r_row : (r_eh - YW'(1) - r_row);

        shifted = DW'(r_ew) << r_k;
        div_ge  = DW'(r_div) >= shifted;
        n_div   = div_ge ? C2W'(DW'(r_div) - shifted) : r_div;
        n_quo   = div_ge ? (r_quo | (QW'(1) << r_k)) : r_quo;
    end

    assign o_q_pop    = (r_state == S_IDLE) & ~i_q_empty;
    assign o_out_load = (r_state == S_OUT) & (~r_out_valid | i_pop);

    always_ff @(posedge i_clk) begin
        r_ew    <= n_ew;
        r_eh    <= n_eh;
        r_total <= n_total;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_red   <= i_q_data.red;
                r_green <= i_q_data.green;
                r_blue  <= i_q_data.blue;
                r_alpha <= i_q_data.alpha;
                r_rep   <= i_q_data.rep;
            end
            S_EVAL: begin
                r_res_index <= 24'(r_pos);
                r_res_rep   <= rep_c;
                r_res_x     <= 12'(dx);
                r_res_y     <= 12'(dy);
                r_div       <= col2;
                r_quo       <= '0;
                r_k         <= KW'(QW - 1);
            end
            S_DIV: begin
                r_div <= n_div;
                r_quo <= n_quo;
                r_k   <= r_k - KW'(1);
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (o_out_load) begin
            r_o_red   <= r_red;
            r_o_green <= r_green;
            r_o_blue  <= r_blue;
            r_o_alpha <= r_alpha;
            r_o_rep   <= r_res_rep;
            r_o_index <= r_res_index;
            r_o_x     <= r_res_x;
            r_o_y     <= r_res_y;
            r_o_done  <= (r_pos >= r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_q_data.clr) begin
                            r_pos <= '0;
                            r_col <= '0;
                            r_row <= '0;
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_pos >= r_total) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= r_pos + PW'(rep_c);
                        if (col2 < C2W'(r_ew)) begin
                            r_col   <= XW'(col2);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_k == '0) begin
                        r_col   <= XW'(n_div);
                        r_row   <= r_row + YW'(n_quo);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = ~r_out_valid;
    assign o_red          = r_o_red;
    assign o_green        = r_o_green;
    assign o_blue         = r_o_blue;
    assign o_alpha        = r_o_alpha;
    assign o_file_index   = r_o_index;
    assign o_repeat_count = r_o_rep;
    assign o_dest_x       = r_o_x;
    assign o_dest_y       = r_o_y;
    assign o_image_done   = r_o_done;

endmodule

// ===== design/tga_pixel_stream_decoder.sv =====
// top level of the tga pixel stream decoder: config registers, front, queue, back
//
// channel   handshake           payload
// input     push / full         i_data_byte, i_start_image
// result    empty / pop         o_red .. o_alpha, o_file_index, o_repeat_count,
//                               o_dest_x, o_dest_y, o_image_done
// config    i_cfg_wr_en         i_cfg_index, i_cfg_data
//
// one byte is taken per cycle while the four-entry pixel queue has room
// the back end evaluates one pixel at a time; a pixel at a row end passes the
// fourteen-step row/column divider, and a pixel past the end is dropped
// synchronous active-low reset, no clearing pass after reset
// full rises when the queue fills; a held result stalls the back end only
`include "tga_pixel_stream_decoder_defines.svh"

module tga_pixel_stream_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_start_image,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue,
    output logic [7:0]                    o_alpha,
    output logic [23:0]                   o_file_index,
    output logic [7:0]                    o_repeat_count,
    output logic [11:0]                   o_dest_x,
    output logic [11:0]                   o_dest_y,
    output logic                          o_image_done,
    input  logic                          i_cfg_wr_en,
    input  logic [tpsd_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [tpsd_pkg::CFG_DW-1:0]   i_cfg_data
);

    tpsd_pkg::t_cfg r_cfg;
    tpsd_pkg::t_pix front_pix, q_pix;
    logic           q_push, q_full, q_empty, q_pop;
    logic           out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_px          <= 13'd1;
            r_cfg.height_px         <= 13'd1;
            r_cfg.pixel_format      <= tpsd_pkg::FMT_24;
            r_cfg.run_length_packed <= 1'b1;
            r_cfg.top_origin        <= 1'b0;
            r_cfg.right_origin      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tpsd_pkg::REG_WIDTH_PX:     r_cfg.width_px          <= i_cfg_data;
                tpsd_pkg::REG_HEIGHT_PX:    r_cfg.height_px         <= i_cfg_data;
                tpsd_pkg::REG_PIXEL_FORMAT: r_cfg.pixel_format      <= i_cfg_data[1:0];
                tpsd_pkg::REG_RLE:          r_cfg.run_length_packed <= i_cfg_data[0];
                tpsd_pkg::REG_TOP_ORIGIN:   r_cfg.top_origin        <= i_cfg_data[0];
                tpsd_pkg::REG_RIGHT_ORIGIN: r_cfg.right_origin      <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign full = q_full;

    tpsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (push & ~q_full),
        .i_data_byte   (i_data_byte),
        .i_start_image (i_start_image),
        .o_push        (q_push),
        .o_pix         (front_pix)
    );

    tpsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_pix),
        .i_pop   (q_pop),
        .o_data  (q_pix),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tpsd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_data       (q_pix),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_file_index   (o_file_index),
        .o_repeat_count (o_repeat_count),
        .o_dest_x       (o_dest_x),
        .o_dest_y       (o_dest_y),
        .o_image_done   (o_image_done),
        .o_out_load     (out_load)
    );

    `TPSD_CHECK(a_rep_range, !empty, (o_repeat_count != 8'd0) && (o_repeat_count <= 8'd128))
    `TPSD_CHECK(a_no_push_when_full, q_push, !q_full)
    `TPSD_CHECK(a_no_overwrite, out_load, empty || pop)
    `TPSD_CHECK_NEXT(a_pop_drains, pop && !empty && !out_load, empty)

endmodule
